[src/escc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and calendar helper functions for the seconds/calendar converter.
package escc_pkg;

    typedef struct packed {
        logic        func;
        logic [31:0] seconds_count;
        logic [11:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } t_in;

    typedef struct packed {
        logic [31:0] counter_value;
        logic [11:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
        logic [4:0]  cal_hour;
        logic [5:0]  cal_minute;
        logic [5:0]  cal_second;
        logic [2:0]  weekday;
    } t_out;

    localparam logic FUNC_TO_CAL     = 1'b0;
    localparam logic FUNC_TO_COUNTER = 1'b1;

    localparam logic [1:0] DSEL_DAY  = 2'd0;
    localparam logic [1:0] DSEL_HOUR = 2'd1;
    localparam logic [1:0] DSEL_MIN  = 2'd2;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;

    localparam logic [25:0] DAY_RECIP        = 26'd50903317;
    localparam int          DAY_RECIP_SHIFT  = 35;
    localparam logic [13:0] HOUR_RECIP       = 14'd9321;
    localparam int          HOUR_RECIP_SHIFT = 21;
    localparam logic [10:0] MIN_RECIP        = 11'd1093;
    localparam int          MIN_RECIP_SHIFT  = 14;

    localparam logic [16:0] RECIP_100   = 17'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       div_save;
        logic [1:0] div_sel;
        logic       year_step;
        logic       month_step;
        logic       f1_q1;
        logic       f1_q2;
        logic       f1_q3;
        logic       f1_ydays;
        logic       f1_days;
        logic       f1_prod;
        logic       f1_cnt;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_stat;

    function automatic logic [4:0] mon_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] mod7_5(input logic [4:0] v);
        logic [4:0] r;
        if (v >= 5'd28) begin
            r = v - 5'd28;
        end else if (v >= 5'd21) begin
            r = v - 5'd21;
        end else if (v >= 5'd14) begin
            r = v - 5'd14;
        end else if (v >= 5'd7) begin
            r = v - 5'd7;
        end else begin
            r = v;
        end
        return r[2:0];
    endfunction

    function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 4'd7) begin
            s = s - 4'd7;
        end
        return s[2:0];
    endfunction

endpackage

[src/escc_datapath.sv]
`timescale 1ns / 1ps
// Datapath: reciprocal-multiply time split, year/month reduction, closed-form day count and result register.
module escc_datapath #(
    parameter int BASE_YEAR_VALUE = 2000
) (
    input  logic           i_clk,
    input  escc_pkg::t_in  i_in,
    input  escc_pkg::t_cmd i_cmd,
    output escc_pkg::t_stat o_stat,
    output escc_pkg::t_out o_out
);
    import escc_pkg::*;

    localparam logic [11:0] YEAR_ORIGIN = 12'(BASE_YEAR_VALUE);
    localparam int          YY_BASE   = BASE_YEAR_VALUE + 4799;
    localparam int          JDN_BASE  = 307 + 365 * YY_BASE + YY_BASE / 4 - YY_BASE / 100
                                        + YY_BASE / 400 - 32045;
    localparam logic [2:0]  WD_BASE    = 3'(JDN_BASE % 7);
    localparam logic [1:0]  MOD4_BASE  = 2'(BASE_YEAR_VALUE % 4);
    localparam logic [6:0]  MOD100_BASE = 7'(BASE_YEAR_VALUE % 100);
    localparam logic [8:0]  MOD400_BASE = 9'(BASE_YEAR_VALUE % 400);
    localparam logic [20:0] LEAPS_BASE = 21'((BASE_YEAR_VALUE - 1) / 4
                                        - (BASE_YEAR_VALUE - 1) / 100
                                        + (BASE_YEAR_VALUE - 1) / 400);

    logic        r_func;
    logic [31:0] r_q;
    logic [16:0] r_r;
    logic [20:0] r_days;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_dayin;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;
    logic [5:0]  r_sec;
    logic [1:0]  r_m4;
    logic [6:0]  r_m100;
    logic [8:0]  r_m400;
    logic [2:0]  r_wd;
    logic [5:0]  r_q1;
    logic [5:0]  r_q2;
    logic [3:0]  r_q3;
    logic        r_leap;
    logic [31:0] r_acc;
    t_out        r_out;

    logic [50:0] day_p;
    logic [26:0] hour_p;
    logic [20:0] min_p;
    logic        leap_cnt;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [11:0] ym1;
    logic [20:0] mul_a;
    logic [16:0] mul_b;
    logic [37:0] mul_p;
    logic [11:0] yc;
    logic [3:0]  mc;
    logic [4:0]  dlim;
    t_out        n_out;

    assign day_p  = 51'(r_q[31:7]) * 51'(DAY_RECIP);
    assign hour_p = 27'(r_r[16:4]) * 27'(HOUR_RECIP);
    assign min_p  = 21'(r_r[11:2]) * 21'(MIN_RECIP);

    assign leap_cnt = (r_m4 == 2'd0) && ((r_m100 != 7'd0) || (r_m400 == 9'd0));
    assign ylen     = leap_cnt ? 9'd366 : 9'd365;
    assign mlen     = mon_len(r_month, leap_cnt);
    assign ym1      = r_year - 12'd1;
    assign dlim     = mon_len(r_month, r_leap);

    assign yc = (i_in.year_in < YEAR_ORIGIN) ? YEAR_ORIGIN : i_in.year_in;
    assign mc = (i_in.month_in == 4'd0) ? 4'd1 :
                (i_in.month_in > 4'd12) ? 4'd12 : i_in.month_in;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.f1_q1) begin
            mul_a = 21'(r_year);
            mul_b = RECIP_100;
        end else if (i_cmd.f1_q2) begin
            mul_a = 21'(ym1);
            mul_b = RECIP_100;
        end else if (i_cmd.f1_q3) begin
            mul_a = 21'(ym1[11:2]);
            mul_b = RECIP_100;
        end else if (i_cmd.f1_prod) begin
            mul_a = r_days;
            mul_b = SECS_PER_DAY;
        end
    end

    assign mul_p = 38'(mul_a) * 38'(mul_b);

    assign o_stat.year_done  = r_days < 21'(ylen);
    assign o_stat.month_done = (r_month == 4'd12) || (r_days < 21'(mlen));

    always_comb begin
        n_out = '0;
        if (r_func == FUNC_TO_COUNTER) begin
            n_out.counter_value = r_acc;
        end else begin
            n_out.cal_year   = r_year;
            n_out.cal_month  = r_month;
            n_out.cal_day    = r_days[4:0] + 5'd1;
            n_out.cal_hour   = r_hour;
            n_out.cal_minute = r_min;
            n_out.cal_second = r_sec;
            n_out.weekday    = add_mod7(r_wd, mod7_5(r_days[4:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_in.func;
            r_q     <= i_in.seconds_count;
            r_year  <= (i_in.func == FUNC_TO_COUNTER) ? yc : YEAR_ORIGIN;
            r_month <= (i_in.func == FUNC_TO_COUNTER) ? mc : 4'd1;
            r_dayin <= i_in.day_in;
            r_hour  <= (i_in.hour_in > 5'd23) ? 5'd23 : i_in.hour_in;
            r_min   <= (i_in.minute_in > 6'd59) ? 6'd59 : i_in.minute_in;
            r_sec   <= (i_in.second_in > 6'd59) ? 6'd59 : i_in.second_in;
            r_m4    <= MOD4_BASE;
            r_m100  <= MOD100_BASE;
            r_m400  <= MOD400_BASE;
            r_wd    <= WD_BASE;
        end

        if (i_cmd.div_step) begin
            case (i_cmd.div_sel)
                DSEL_DAY: begin
                    r_days <= 21'(day_p[DAY_RECIP_SHIFT +: 16]);
                end
                DSEL_HOUR: begin
                    r_hour <= hour_p[HOUR_RECIP_SHIFT +: 5];
                end
                DSEL_MIN: begin
                    r_min <= min_p[MIN_RECIP_SHIFT +: 6];
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.div_save) begin
            case (i_cmd.div_sel)
                DSEL_DAY: begin
                    r_r <= r_q[16:0] - 17'(r_days[15:0]) * SECS_PER_DAY;
                end
                DSEL_HOUR: begin
                    r_r <= r_r - 17'(r_hour) * SECS_PER_HOUR;
                end
                DSEL_MIN: begin
                    r_sec <= r_r[5:0] - r_min * SECS_PER_MIN[5:0];
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.year_step) begin
            r_days <= r_days - 21'(ylen);
            r_year <= r_year + 12'd1;
            r_m4   <= r_m4 + 2'd1;
            r_m100 <= (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
            r_m400 <= (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
            r_wd   <= add_mod7(r_wd, leap_cnt ? 3'd2 : 3'd1);
        end

        if (i_cmd.month_step) begin
            r_days  <= r_days - 21'(mlen);
            r_month <= r_month + 4'd1;
            r_wd    <= add_mod7(r_wd, 3'(mlen - 5'd28));
        end

        if (i_cmd.f1_q1) begin
            r_q1 <= mul_p[RECIP_SHIFT +: 6];
        end

        if (i_cmd.f1_q2) begin
            r_q2   <= mul_p[RECIP_SHIFT +: 6];
            r_leap <= (r_year[1:0] == 2'd0)
                      && ((r_year != 12'(r_q1) * 12'd100) || (r_q1[1:0] == 2'd0));
        end

        if (i_cmd.f1_q3) begin
            r_q3    <= mul_p[RECIP_SHIFT +: 4];
            r_dayin <= (r_dayin == 5'd0) ? 5'd1 : (r_dayin > dlim) ? dlim : r_dayin;
        end

        if (i_cmd.f1_ydays) begin
            r_days <= 21'd365 * 21'(r_year - YEAR_ORIGIN) + 21'(ym1[11:2])
                      - 21'(r_q2) + 21'(r_q3) - LEAPS_BASE;
        end

        if (i_cmd.f1_days) begin
            r_days <= r_days + 21'(cum_days(r_month))
                      + 21'(r_leap && (r_month > 4'd2)) + 21'(r_dayin) - 21'd1;
        end

        if (i_cmd.f1_prod) begin
            r_acc <= mul_p[31:0];
        end

        if (i_cmd.f1_cnt) begin
            r_acc <= r_acc + 32'(r_hour) * 32'd3600 + 32'(r_min) * 32'd60 + 32'(r_sec);
        end

        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

[src/escc_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences the divider, year and month loops and the counter build, owns the handshakes.
module escc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_func,
    input  logic            i_out_ready,
    input  escc_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output escc_pkg::t_cmd  o_cmd
);
    import escc_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV      = 4'd1;
    localparam logic [3:0] ST_DIV_END  = 4'd2;
    localparam logic [3:0] ST_YEAR     = 4'd3;
    localparam logic [3:0] ST_MONTH    = 4'd4;
    localparam logic [3:0] ST_F1_Q1    = 4'd5;
    localparam logic [3:0] ST_F1_Q2    = 4'd6;
    localparam logic [3:0] ST_F1_Q3    = 4'd7;
    localparam logic [3:0] ST_F1_YDAYS = 4'd8;
    localparam logic [3:0] ST_F1_DAYS  = 4'd9;
    localparam logic [3:0] ST_F1_PROD  = 4'd10;
    localparam logic [3:0] ST_F1_CNT   = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    if (i_func == FUNC_TO_CAL) begin
                        n_state = ST_DIV;
                        n_sel   = DSEL_DAY;
                    end else begin
                        n_state = ST_F1_Q1;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = r_sel;
                n_state      = ST_DIV_END;
            end
            ST_DIV_END: begin
                cmd.div_save = 1'b1;
                cmd.div_sel  = r_sel;
                case (r_sel)
                    DSEL_DAY: begin
                        n_sel   = DSEL_HOUR;
                        n_state = ST_DIV;
                    end
                    DSEL_HOUR: begin
                        n_sel   = DSEL_MIN;
                        n_state = ST_DIV;
                    end
                    default: begin
                        n_state = ST_YEAR;
                    end
                endcase
            end
            ST_YEAR: begin
                if (i_stat.year_done) begin
                    n_state = ST_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (i_stat.month_done) begin
                    n_state = ST_DONE;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_F1_Q1: begin
                cmd.f1_q1 = 1'b1;
                n_state   = ST_F1_Q2;
            end
            ST_F1_Q2: begin
                cmd.f1_q2 = 1'b1;
                n_state   = ST_F1_Q3;
            end
            ST_F1_Q3: begin
                cmd.f1_q3 = 1'b1;
                n_state   = ST_F1_YDAYS;
            end
            ST_F1_YDAYS: begin
                cmd.f1_ydays = 1'b1;
                n_state      = ST_F1_DAYS;
            end
            ST_F1_DAYS: begin
                cmd.f1_days = 1'b1;
                n_state     = ST_F1_PROD;
            end
            ST_F1_PROD: begin
                cmd.f1_prod = 1'b1;
                n_state     = ST_F1_CNT;
            end
            ST_F1_CNT: begin
                cmd.f1_cnt = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= DSEL_DAY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

[src/epoch_seconds_calendar_converter.sv]
`timescale 1ns / 1ps
// Top level: converts between a seconds counter and a Gregorian date and time.
//
// Input channel (i_in_valid / o_in_ready / i_in) takes one request per transfer.
// func 0 splits seconds_count into date, time and weekday; func 1 clamps the
// date and time fields and builds the seconds counter (wrapping modulo 2^32).
// Output channel (o_out_valid / i_out_ready / o_out) carries one result per request.
//
// One request is in flight at a time. A func 0 request runs three reciprocal
// multiplications, each followed by a remainder step, then steps off up to 136
// whole years and then up to 11 whole months from the day count, one per cycle.
// A func 1 request builds its counter through the shared multiplier.
// The next request is taken the cycle after its result is loaded.
// The result sits in an output register, so a new request is taken while the
// previous result waits; a finished result holds until that register is free.
// Reset (synchronous, active low) returns the block to idle and drops any
// pending result.
module epoch_seconds_calendar_converter #(
    parameter int BASE_YEAR_VALUE = 2000
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  escc_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output escc_pkg::t_out o_out
);
    import escc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    escc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_in.func),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    escc_datapath #(
        .BASE_YEAR_VALUE (BASE_YEAR_VALUE)
    ) u_datapath (
        .i_clk  (i_clk),
        .i_in   (i_in),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_out  (o_out)
    );

endmodule

[tb/sv/tb_epoch_seconds_calendar_converter.sv]
`timescale 1ns / 1ps
// Testbench for the seconds/calendar converter: directed and random requests, scoreboard checks.
module tb_epoch_seconds_calendar_converter;

    import escc_pkg::*;

    localparam int unsigned YEAR_ORIGIN  = 2000;
    localparam int unsigned SECS_DAY     = 86400;
    localparam int unsigned SECS_HOUR    = 3600;
    localparam int unsigned SECS_MIN     = 60;
    localparam int          RANDOM_ITEMS = 450;
    localparam int          QUIET_ITEMS  = 60;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 250;
    localparam int          TIMEOUT_NS   = 5_000_000;

    class calendar_scoreboard;
        t_out        expected_results[$];
        int unsigned n_to_cal;
        int unsigned n_to_counter;
        int unsigned n_checked;
        int unsigned n_errors;

        function new();
            n_to_cal     = 0;
            n_to_counter = 0;
            n_checked    = 0;
            n_errors     = 0;
        endfunction

        function bit is_leap(int unsigned y);
            return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        endfunction

        function int unsigned year_days(int unsigned y);
            return is_leap(y) ? 366 : 365;
        endfunction

        function int unsigned month_days(int unsigned y, int unsigned m);
            int unsigned len;
            case (m)
                2:             len = is_leap(y) ? 29 : 28;
                4, 6, 9, 11:   len = 30;
                default:       len = 31;
            endcase
            return len;
        endfunction

        function int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
            int unsigned a;
            int unsigned yy;
            int unsigned mm;
            int unsigned jdn;
            a   = (14 - m) / 12;
            yy  = y + 4800 - a;
            mm  = m + 12 * a - 3;
            jdn = d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
            return jdn % 7;
        endfunction

        function t_out convert(t_in req);
            t_out        res;
            int unsigned days;
            int unsigned rem;
            int unsigned y;
            int unsigned m;
            int unsigned d;
            int unsigned h;
            int unsigned mi;
            int unsigned s;
            int unsigned k;
            res = '0;
            if (req.func == FUNC_TO_CAL) begin
                days = req.seconds_count / SECS_DAY;
                rem  = req.seconds_count - days * SECS_DAY;
                y    = YEAR_ORIGIN;
                m    = 1;
                while (days >= year_days(y)) begin
                    days -= year_days(y);
                    y++;
                end
                while (m < 12 && days >= month_days(y, m)) begin
                    days -= month_days(y, m);
                    m++;
                end
                days++;
                res.cal_year   = 12'(y);
                res.cal_month  = 4'(m);
                res.cal_day    = 5'(days);
                res.cal_hour   = 5'(rem / SECS_HOUR);
                res.cal_minute = 6'((rem % SECS_HOUR) / SECS_MIN);
                res.cal_second = 6'(rem % SECS_MIN);
                res.weekday    = 3'(day_of_week(y, m, days));
            end else begin
                y  = req.year_in;
                m  = req.month_in;
                d  = req.day_in;
                h  = req.hour_in;
                mi = req.minute_in;
                s  = req.second_in;
                if (y < YEAR_ORIGIN) y = YEAR_ORIGIN;
                if (m < 1) m = 1;
                if (m > 12) m = 12;
                if (d < 1) d = 1;
                if (d > month_days(y, m)) d = month_days(y, m);
                if (h > 23) h = 23;
                if (mi > 59) mi = 59;
                if (s > 59) s = 59;
                days = 0;
                for (k = YEAR_ORIGIN; k < y; k++) days += year_days(k);
                for (k = 1; k < m; k++) days += month_days(y, k);
                days += d - 1;
                res.counter_value = days * SECS_DAY + h * SECS_HOUR + mi * SECS_MIN + s;
            end
            return res;
        endfunction

        function void note_request(t_in req);
            if (req.func == FUNC_TO_CAL) n_to_cal++;
            else n_to_counter++;
            expected_results.push_back(convert(req));
        endfunction

        task report(string what);
            $display("%0t ns mismatch: %s", $time, what);
            n_errors++;
        endtask

        task check_field(string name, int unsigned got, int unsigned want);
            if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_result(t_out got);
            t_out want;
            if (expected_results.size() == 0) begin
                report("result arrived with nothing pending");
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                check_field("counter_value", got.counter_value, want.counter_value);
                check_field("cal_year", got.cal_year, want.cal_year);
                check_field("cal_month", got.cal_month, want.cal_month);
                check_field("cal_day", got.cal_day, want.cal_day);
                check_field("cal_hour", got.cal_hour, want.cal_hour);
                check_field("cal_minute", got.cal_minute, want.cal_minute);
                check_field("cal_second", got.cal_second, want.cal_second);
                check_field("weekday", got.weekday, want.weekday);
            end
        endtask

        task check_drained();
            if (expected_results.size() != 0)
                report($sformatf("%0d results never arrived", expected_results.size()));
        endtask
    endclass

    logic   i_clk;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   o_in_ready;
    t_in    i_in        = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    t_out   o_out;

    calendar_scoreboard sb = new();
    bit hold_request = 1'b0;
    bit no_idle      = 1'b0;

    epoch_seconds_calendar_converter #(
        .BASE_YEAR_VALUE(YEAR_ORIGIN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", sb.expected_results.size());
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out);
            if (i_in_valid && o_in_ready) sb.note_request(i_in);
        end
    end

    function t_in new_cal_req(int unsigned cnt);
        t_in r;
        r               = t_in'({$urandom, $urandom, $urandom});
        r.func          = FUNC_TO_CAL;
        r.seconds_count = cnt;
        return r;
    endfunction

    function t_in new_cnt_req(int unsigned y, int unsigned mo, int unsigned d,
                              int unsigned h, int unsigned mi, int unsigned s);
        t_in r;
        r.func          = FUNC_TO_COUNTER;
        r.seconds_count = $urandom;
        r.year_in       = 12'(y);
        r.month_in      = 4'(mo);
        r.day_in        = 5'(d);
        r.hour_in       = 5'(h);
        r.minute_in     = 6'(mi);
        r.second_in     = 6'(s);
        return r;
    endfunction

    function t_in random_request();
        t_in         r;
        int unsigned pick;
        int unsigned anchor;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            r = new_cal_req($urandom);
        end else if (pick < 45) begin
            // land near a month or year boundary
            anchor = sb.convert(new_cnt_req($urandom_range(2000, 2135), $urandom_range(1, 12),
                                            $urandom_range(0, 1) ? 1 : 31, 0, 0, 0)).counter_value;
            r = new_cal_req(anchor + $urandom_range(0, 2 * SECS_DAY) - SECS_DAY);
        end else if (pick < 90) begin
            r = new_cnt_req($urandom_range(2000, 2136), $urandom_range(1, 12),
                            $urandom_range(1, 31), $urandom_range(0, 23),
                            $urandom_range(0, 59), $urandom_range(0, 59));
        end else begin
            r      = t_in'({$urandom, $urandom, $urandom});
            r.func = FUNC_TO_COUNTER;
        end
        return r;
    endfunction

    task send_request(t_in req, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function int pick_gap();
        if (no_idle || $urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, 7);
    endfunction

    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        t_in directed[$];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(new_cal_req(0));
        directed.push_back(new_cal_req(SECS_DAY - 1));
        directed.push_back(new_cal_req(SECS_DAY));
        directed.push_back(new_cal_req(59 * SECS_DAY));
        directed.push_back(new_cal_req(60 * SECS_DAY));
        directed.push_back(new_cal_req(366 * SECS_DAY - 1));
        directed.push_back(new_cal_req(366 * SECS_DAY));
        directed.push_back(new_cal_req((36525 + 58) * SECS_DAY));
        directed.push_back(new_cal_req((36525 + 59) * SECS_DAY + 3661));
        directed.push_back(new_cal_req(32'h8000_0000));
        directed.push_back(new_cal_req(32'hFFFF_FFFF));
        directed.push_back(new_cnt_req(0, 0, 0, 0, 0, 0));
        directed.push_back(new_cnt_req(1999, 12, 31, 23, 59, 59));
        directed.push_back(new_cnt_req(2000, 2, 31, 0, 0, 0));
        directed.push_back(new_cnt_req(2001, 2, 30, 1, 1, 1));
        directed.push_back(new_cnt_req(2100, 2, 29, 0, 0, 0));
        directed.push_back(new_cnt_req(2024, 4, 31, 31, 63, 63));
        directed.push_back(new_cnt_req(2024, 15, 0, 12, 30, 30));
        directed.push_back(new_cnt_req(2024, 0, 31, 24, 60, 60));
        directed.push_back(new_cnt_req(2106, 2, 7, 6, 28, 15));
        directed.push_back(new_cnt_req(2106, 2, 7, 6, 28, 16));
        directed.push_back(new_cnt_req(2136, 12, 31, 23, 59, 59));
        directed.push_back(new_cnt_req(4095, 15, 31, 31, 63, 63));
        foreach (directed[i]) send_request(directed[i], pick_gap());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 40) hold_request = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_ITEMS) no_idle = 1'b1;
            send_request(random_request(), pick_gap());
        end
        i_in_valid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_drained();

        $display("run covered %0d counter-to-calendar and %0d calendar-to-counter requests,",
                 sb.n_to_cal, sb.n_to_counter);
        $display("%0d results checked field by field, %0d mismatches", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
src/escc_pkg.sv
src/escc_datapath.sv
src/escc_ctrl.sv
src/epoch_seconds_calendar_converter.sv
tb/sv/tb_epoch_seconds_calendar_converter.sv
